>>> src/pmm_pkg.sv
// Shared operation codes and item field widths for the pixel mask map.
package pmm_pkg;

  localparam int OP_W    = 3;
  localparam int CHIP_FW = 5;
  localparam int COL_FW  = 6;
  localparam int ROW_FW  = 7;

  // Number of columns that form one double column.
  localparam int COLS_PER_DCOL = 2;

  typedef enum logic [OP_W-1:0] {
    OP_SEL_ALL       = 3'd0,
    OP_SEL_CHIP      = 3'd1,
    OP_SEL_PIXEL     = 3'd2,
    OP_QUERY_PIXEL   = 3'd3,
    OP_QUERY_CHIP    = 3'd4,
    OP_QUERY_DCOL    = 3'd5,
    OP_QUERY_COL     = 3'd6,
    OP_QUERY_COL_ANY = 3'd7
  } op_t;

endpackage

>>> src/pmm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module pmm_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/pmm_clear.sv
// Post-reset sweep that walks every memory address once so the mask starts empty.
module pmm_clear #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst,
  output logic              busy,
  output logic [ADDR_W-1:0] addr
);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      addr <= '0;
    end else if (busy) begin
      if (addr == ADDR_W'(DEPTH - 1)) begin
        busy <= 1'b0;
      end else begin
        addr <= addr + 1'b1;
      end
    end
  end

endmodule

>>> src/pixel_mask_map_region_query.sv
// Pixel selection mask with per-chip and per-column summaries, answering region queries.
// An accepted word waits in the work stage; its result is registered onto the output.
// Throughput: one word per cycle unless the output stalls; the mask word memory is read at
// accept and written from the work stage; a one-entry forward covers the word just written.
// Reset: synchronous; afterwards a clearing sweep over max(NUM_CHIPS*ceil(NUM_COLUMNS/2),
// NUM_COLUMNS) addresses (416 by default) zeroes the memories while no input is taken.
module pixel_mask_map_region_query #(
  parameter int NUM_CHIPS   = 16,
  parameter int NUM_COLUMNS = 52,
  parameter int NUM_ROWS    = 80
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // op[2:0], chip[7:3], column_index[13:8], row_index[20:14]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata   // hit[0], range_error[1]
);

  import pmm_pkg::*;

  localparam int NDCOL     = (NUM_COLUMNS + 1) / 2;
  localparam int WORD_W    = COLS_PER_DCOL * NUM_ROWS;
  localparam int WDEPTH    = NUM_CHIPS * NDCOL;
  localparam int WADDR_W   = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int CHIP_W    = (NUM_CHIPS > 1) ? $clog2(NUM_CHIPS) : 1;
  localparam int COL_W     = $clog2(NUM_COLUMNS);
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int CLR_DEPTH = (WDEPTH > NUM_COLUMNS) ? WDEPTH : NUM_COLUMNS;
  localparam int CLR_W     = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;

  // Input word fields.
  op_t               in_op;
  logic [CHIP_FW-1:0] in_chip;
  logic [COL_FW-1:0]  in_col;
  logic [ROW_FW-1:0]  in_row;

  assign in_op   = op_t'(s_tdata[OP_W-1:0]);
  assign in_chip = s_tdata[OP_W +: CHIP_FW];
  assign in_col  = s_tdata[OP_W+CHIP_FW +: COL_FW];
  assign in_row  = s_tdata[OP_W+CHIP_FW+COL_FW +: ROW_FW];

  logic chip_bad, col_bad, row_bad, dcol_bad;
  logic in_err, in_word_rd;
  logic [COL_FW-1:0]  in_dcol;
  logic [WADDR_W-1:0] in_waddr;
  logic [BIT_W-1:0]   in_bit;
  logic               accept;

  assign chip_bad = {1'b0, in_chip} >= (CHIP_FW+1)'(NUM_CHIPS);
  assign col_bad  = {1'b0, in_col} >= (COL_FW+1)'(NUM_COLUMNS);
  assign row_bad  = {1'b0, in_row} >= (ROW_FW+1)'(NUM_ROWS);
  assign dcol_bad = {in_col, 1'b0} >= (COL_FW+1)'(NUM_COLUMNS);

  always_comb begin
    case (in_op)
      OP_SEL_ALL:                    in_err = 1'b0;
      OP_SEL_CHIP, OP_QUERY_CHIP:    in_err = chip_bad;
      OP_SEL_PIXEL, OP_QUERY_PIXEL:  in_err = chip_bad | col_bad | row_bad;
      OP_QUERY_DCOL:                 in_err = chip_bad | dcol_bad;
      OP_QUERY_COL:                  in_err = chip_bad | col_bad;
      OP_QUERY_COL_ANY:              in_err = col_bad;
      default:                       in_err = 1'b0;
    endcase
  end

  // A memory word holds both columns of one double column of one chip.
  assign in_dcol    = (in_op == OP_QUERY_DCOL) ? in_col : (in_col >> 1);
  assign in_waddr   = WADDR_W'(32'(in_chip[CHIP_W-1:0]) * NDCOL + 32'(in_dcol));
  assign in_bit     = BIT_W'(((in_col[0] && in_op != OP_QUERY_DCOL) ? NUM_ROWS : 0)
                             + 32'(in_row));
  assign in_word_rd = !in_err &&
                      (in_op inside {OP_SEL_PIXEL, OP_QUERY_PIXEL, OP_QUERY_DCOL, OP_QUERY_COL});

  // Clearing sweep.
  logic             clr_busy;
  logic [CLR_W-1:0] clr_addr;

  pmm_clear #(.DEPTH(CLR_DEPTH), .ADDR_W(CLR_W)) u_clear (
    .clk  (clk),
    .rst  (rst),
    .busy (clr_busy),
    .addr (clr_addr)
  );

  // Work stage registers.
  logic               st_valid;
  op_t                st_op;
  logic               st_err;
  logic [CHIP_W-1:0]  st_chip;
  logic               st_col0;
  logic [BIT_W-1:0]   st_bit;
  logic [WADDR_W-1:0] st_waddr;
  logic [COL_W-1:0]   st_caddr;
  logic               adv;

  assign adv      = st_valid && (!m_tvalid || m_tready);
  assign s_tready = !clr_busy && (!st_valid || adv);
  assign accept   = s_tvalid && s_tready;

  // Memories and forwarding.
  logic               w_we, c_we;
  logic [WADDR_W-1:0] w_waddr;
  logic [WORD_W-1:0]  w_wdata, w_rdata, word;
  logic [COL_W-1:0]   c_waddr;
  logic [0:0]         c_wdata, c_rdata;
  logic               fwd_valid, cfwd_valid;
  logic [WADDR_W-1:0] fwd_addr;
  logic [WORD_W-1:0]  fwd_data;
  logic [COL_W-1:0]   cfwd_addr;
  logic               cbit;
  logic               set_pixel;

  logic [NUM_CHIPS-1:0] chip_full, chip_any;
  logic [NUM_ROWS-1:0]  half;
  logic                 hit;

  assign set_pixel = adv && !st_err && st_op == OP_SEL_PIXEL;

  assign word = (fwd_valid && fwd_addr == st_waddr) ? fwd_data : w_rdata;
  assign cbit = (cfwd_valid && cfwd_addr == st_caddr) ? 1'b1 : c_rdata[0];
  assign half = st_col0 ? word[WORD_W-1:NUM_ROWS] : word[NUM_ROWS-1:0];

  always_comb begin
    if (clr_busy) begin
      w_we    = 32'(clr_addr) < WDEPTH;
      w_waddr = WADDR_W'(clr_addr);
      w_wdata = '0;
      c_we    = 32'(clr_addr) < NUM_COLUMNS;
      c_waddr = COL_W'(clr_addr);
      c_wdata = 1'b0;
    end else begin
      w_we    = set_pixel;
      w_waddr = st_waddr;
      w_wdata = word | (WORD_W'(1) << st_bit);
      c_we    = set_pixel;
      c_waddr = st_caddr;
      c_wdata = 1'b1;
    end
  end

  pmm_ram #(.WIDTH(WORD_W), .DEPTH(WDEPTH), .ADDR_W(WADDR_W)) u_word_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .re    (accept && in_word_rd),
    .raddr (in_waddr),
    .rdata (w_rdata)
  );

  pmm_ram #(.WIDTH(1), .DEPTH(NUM_COLUMNS), .ADDR_W(COL_W)) u_col_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .re    (accept && !in_err && in_op == OP_QUERY_COL_ANY),
    .raddr (in_col[COL_W-1:0]),
    .rdata (c_rdata)
  );

  // A whole-chip selection is carried by chip_full rather than by writing the words.
  always_comb begin
    case (st_op)
      OP_QUERY_PIXEL:   hit = word[st_bit] | chip_full[st_chip];
      OP_QUERY_CHIP:    hit = chip_any[st_chip];
      OP_QUERY_DCOL:    hit = (|word) | chip_full[st_chip];
      OP_QUERY_COL:     hit = (|half) | chip_full[st_chip];
      OP_QUERY_COL_ANY: hit = cbit | (|chip_full);
      default:          hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid   <= 1'b0;
      m_tvalid   <= 1'b0;
      fwd_valid  <= 1'b0;
      cfwd_valid <= 1'b0;
      chip_full  <= '0;
      chip_any   <= '0;
    end else begin
      if (accept) begin
        st_valid <= 1'b1;
      end else if (adv) begin
        st_valid <= 1'b0;
      end

      if (adv) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (set_pixel) begin
        fwd_valid  <= 1'b1;
        cfwd_valid <= 1'b1;
      end

      if (adv && !st_err) begin
        case (st_op)
          OP_SEL_ALL: begin
            chip_full <= '1;
            chip_any  <= '1;
          end
          OP_SEL_CHIP: begin
            chip_full[st_chip] <= 1'b1;
            chip_any[st_chip]  <= 1'b1;
          end
          OP_SEL_PIXEL: begin
            chip_any[st_chip] <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_op    <= in_op;
      st_err   <= in_err;
      st_chip  <= in_chip[CHIP_W-1:0];
      st_col0  <= in_col[0];
      st_bit   <= in_bit;
      st_waddr <= in_waddr;
      st_caddr <= in_col[COL_W-1:0];
    end
    if (set_pixel) begin
      fwd_addr  <= st_waddr;
      fwd_data  <= w_wdata;
      cfwd_addr <= st_caddr;
    end
    if (adv) begin
      m_tdata <= {6'b0, st_err, hit & !st_err};
    end
  end

endmodule

>>> src/pmm_checker.sv
// Port-level checks for the pixel mask map, bound to the top level.
module pmm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [23:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata
);

  // The clearing sweep keeps the input closed right after reset.
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input open during clearing sweep");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output word changed");

  // An errored item never reports a hit.
  a_err_no_hit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] |-> !m_tdata[0])
    else $error("hit reported with range error");

  // A fresh output word follows an input word taken into the work stage.
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("output word without input word");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:2] == 6'b0)
    else $error("output padding not zero");

endmodule

bind pixel_mask_map_region_query pmm_checker u_pmm_checker (.*);

>>> sim/tb_top.sv
// Self-checking testbench for the pixel mask map: directed rows around random region traffic.
module tb_top;
  import pmm_pkg::*;

  localparam int N_CHIPS  = 16;
  localparam int N_COLS   = 52;
  localparam int N_ROWS   = 80;
  localparam int N_PIXELS = N_CHIPS * N_COLS * N_ROWS;

  localparam int PHASE_WORDS    = 125;
  localparam int HOLD_AT        = 60;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct packed {
    logic hit;
    logic err;
  } answer_t;

  typedef struct {
    bit      typed;
    answer_t val;
  } typed_ans_t;

  typedef struct {
    op_t        op;
    logic [4:0] chip;
    logic [5:0] col;
    logic [6:0] row;
    typed_ans_t ans;
  } dir_row_t;

  typedef struct {
    logic [4:0] chip;
    logic [5:0] col;
    logic [6:0] row;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;  // op[2:0], chip[7:3], column_index[13:8], row_index[20:14]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;       // hit[0], range_error[1]

  // Mirror of the selection mask and its summary flags.
  bit mask_pix [N_PIXELS];
  bit mask_chip_any [N_CHIPS];
  bit mask_col_any [N_CHIPS*N_COLS];
  bit mask_col_any_chip [N_COLS];

  answer_t    answer_q[$];
  typed_ans_t typed_q[$];
  dir_row_t   dir_rows[$];
  pixel_t     picked_q[$];

  int n_accepted = 0;
  int n_errors = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  pixel_mask_map_region_query #(
    .NUM_CHIPS(N_CHIPS),
    .NUM_COLUMNS(N_COLS),
    .NUM_ROWS(N_ROWS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  function automatic int pix_index(int c, int col, int row);
    return row + N_ROWS * (col + N_COLS * c);
  endfunction

  function automatic void fill_chip(int c);
    mask_chip_any[c] = 1'b1;
    for (int k = 0; k < N_COLS; k++) begin
      mask_col_any[c*N_COLS + k] = 1'b1;
      mask_col_any_chip[k] = 1'b1;
      for (int r = 0; r < N_ROWS; r++) mask_pix[pix_index(c, k, r)] = 1'b1;
    end
  endfunction

  // Applies one word to the mirror and returns the answer the block should give.
  function automatic answer_t mask_step(op_t op, logic [4:0] c, logic [5:0] col,
                                        logic [6:0] row);
    answer_t a;
    bit c_bad, col_bad, row_bad;
    int first;
    a = '0;
    c_bad = (c >= N_CHIPS);
    col_bad = (col >= N_COLS);
    row_bad = (row >= N_ROWS);
    first = int'(col) * COLS_PER_DCOL;
    case (op)
      OP_SEL_ALL: begin
        for (int k = 0; k < N_CHIPS; k++) fill_chip(k);
      end
      OP_SEL_CHIP: begin
        if (c_bad) a.err = 1'b1;
        else fill_chip(c);
      end
      OP_SEL_PIXEL: begin
        if (c_bad || col_bad || row_bad) begin
          a.err = 1'b1;
        end else begin
          mask_pix[pix_index(c, col, row)] = 1'b1;
          mask_chip_any[c] = 1'b1;
          mask_col_any[c*N_COLS + col] = 1'b1;
          mask_col_any_chip[col] = 1'b1;
        end
      end
      OP_QUERY_PIXEL: begin
        if (c_bad || col_bad || row_bad) a.err = 1'b1;
        else a.hit = mask_pix[pix_index(c, col, row)];
      end
      OP_QUERY_CHIP: begin
        if (c_bad) a.err = 1'b1;
        else a.hit = mask_chip_any[c];
      end
      OP_QUERY_DCOL: begin
        if (c_bad || first >= N_COLS) begin
          a.err = 1'b1;
        end else begin
          a.hit = mask_col_any[c*N_COLS + first];
          // With an odd column count the last double column has no partner.
          if (first + 1 < N_COLS) a.hit = a.hit | mask_col_any[c*N_COLS + first + 1];
        end
      end
      OP_QUERY_COL: begin
        if (c_bad || col_bad) a.err = 1'b1;
        else a.hit = mask_col_any[c*N_COLS + col];
      end
      default: begin
        if (col_bad) a.err = 1'b1;
        else a.hit = mask_col_any_chip[col];
      end
    endcase
    return a;
  endfunction

  task automatic report_mismatch(string what, answer_t got, answer_t want);
    $display("mismatch at %0t: %s (hit %0b/%0b, range_error %0b/%0b)",
             $realtime, what, got.hit, want.hit, got.err, want.err);
    n_errors++;
  endtask

  // Input and output monitor: predicts on every accepted word, checks every result.
  always @(posedge clk) begin : monitor
    answer_t    want;
    answer_t    got;
    typed_ans_t t;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        want = mask_step(op_t'(s_tdata[2:0]), s_tdata[7:3], s_tdata[13:8], s_tdata[20:14]);
        if (typed_q.size() != 0) begin
          t = typed_q.pop_front();
          if (t.typed) want = t.val;
        end
        answer_q.push_back(want);
        n_accepted <= n_accepted + 1;
      end
      if (m_tvalid && m_tready) begin
        got.hit = m_tdata[0];
        got.err = m_tdata[1];
        if (answer_q.size() == 0) begin
          report_mismatch("result word with nothing expected", got, '0);
        end else begin
          want = answer_q.pop_front();
          if (got.hit !== want.hit) report_mismatch("hit", got, want);
          if (got.err !== want.err) report_mismatch("range_error", got, want);
        end
      end
    end
  end

  // Result side: random stalls, plus one long hold-off so the input backs up.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_accepted >= HOLD_AT) begin
      m_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("pixel_mask_map_region_query regression: fail");
      $finish;
    end
  end

  task automatic send_word(op_t op, logic [4:0] c, logic [5:0] col, logic [6:0] row,
                           typed_ans_t ans);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    typed_q.push_back(ans);
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, row, col, c, op};
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic void add_row(op_t op, int c, int col, int row, int hit, int err);
    dir_row_t d;
    d.op = op;
    d.chip = 5'(c);
    d.col = 6'(col);
    d.row = 7'(row);
    d.ans.typed = 1'b1;
    d.ans.val.hit = 1'(hit);
    d.ans.val.err = 1'(err);
    dir_rows.push_back(d);
  endfunction

  // Mostly in range; now and then the whole field width to reach every bit and the errors.
  function automatic logic [4:0] pick_chip();
    return ($urandom_range(99) < 8) ? 5'($urandom_range(31)) : 5'($urandom_range(N_CHIPS-1));
  endfunction

  function automatic logic [5:0] pick_col();
    return ($urandom_range(99) < 8) ? 6'($urandom_range(63)) : 6'($urandom_range(N_COLS-1));
  endfunction

  function automatic logic [6:0] pick_row();
    return ($urandom_range(99) < 8) ? 7'($urandom_range(127)) : 7'($urandom_range(N_ROWS-1));
  endfunction

  task automatic send_random(output int sent);
    typed_ans_t none;
    pixel_t     p;
    op_t        op;
    int         r;
    none = '{typed: 1'b0, val: '0};
    sent = 1;
    r = $urandom_range(99);
    p.chip = pick_chip();
    p.col = pick_col();
    p.row = pick_row();
    if (r < 2) op = OP_SEL_CHIP;
    else if (r < 27) op = OP_SEL_PIXEL;
    else if (r < 47) op = OP_QUERY_PIXEL;
    else if (r < 59) op = OP_QUERY_CHIP;
    else if (r < 71) op = OP_QUERY_DCOL;
    else if (r < 85) op = OP_QUERY_COL;
    else op = OP_QUERY_COL_ANY;
    if (op == OP_QUERY_DCOL && $urandom_range(99) >= 8) p.col = 6'($urandom_range(N_COLS/2 - 1));
    if (op == OP_QUERY_PIXEL && picked_q.size() != 0 && $urandom_range(1) == 1)
      p = picked_q[$urandom_range(picked_q.size() - 1)];
    send_word(op, p.chip, p.col, p.row, none);
    if (op == OP_SEL_PIXEL && p.chip < N_CHIPS && p.col < N_COLS && p.row < N_ROWS) begin
      picked_q.push_back(p);
      // Read back the word just written, to cover the write-to-read forward.
      if ($urandom_range(99) < 30) begin
        send_word(OP_QUERY_PIXEL, p.chip, p.col, p.row, none);
        sent = 2;
      end
    end
  endtask

  initial begin : stimulus
    int n_head;
    int sent;
    int count;
    n_head = 0;
    // Start-up answers, range errors, ignored fields, then a first pixel and a first chip.
    add_row(OP_QUERY_PIXEL,   0,  0,   0, 0, 0);
    add_row(OP_QUERY_CHIP,   15, 63, 127, 0, 0);
    add_row(OP_QUERY_COL_ANY, 31, 51, 127, 0, 0);
    add_row(OP_QUERY_DCOL,   15, 25,   0, 0, 0);
    add_row(OP_QUERY_PIXEL,  16,  0,   0, 0, 1);
    add_row(OP_QUERY_PIXEL,   0, 52,   0, 0, 1);
    add_row(OP_QUERY_PIXEL,   0,  0,  80, 0, 1);
    add_row(OP_SEL_PIXEL,    31, 63, 127, 0, 1);
    add_row(OP_SEL_CHIP,     16,  0,   0, 0, 1);
    add_row(OP_QUERY_DCOL,    0, 26,   0, 0, 1);
    add_row(OP_QUERY_COL_ANY,  0, 52,   0, 0, 1);
    add_row(OP_QUERY_CHIP,   31,  0,   0, 0, 1);
    add_row(OP_QUERY_COL,    15, 52,  79, 0, 1);
    add_row(OP_SEL_PIXEL,    15, 51,  79, 0, 0);
    add_row(OP_QUERY_PIXEL,  15, 51,  79, 1, 0);
    add_row(OP_SEL_PIXEL,    15, 51,  79, 0, 0);
    add_row(OP_QUERY_DCOL,   15, 25,   0, 1, 0);
    add_row(OP_QUERY_PIXEL,  15, 51,  78, 0, 0);
    add_row(OP_QUERY_COL_ANY,  0, 51,   0, 1, 0);
    add_row(OP_SEL_CHIP,      0, 63, 127, 0, 0);
    add_row(OP_QUERY_PIXEL,   0, 51,  79, 1, 0);
    n_head = dir_rows.size();
    // Selecting the whole module saturates the mask, so it runs last.
    add_row(OP_SEL_ALL,      31, 63, 127, 0, 0);
    add_row(OP_QUERY_PIXEL,   7, 30,  40, 1, 0);
    add_row(OP_QUERY_PIXEL,  16,  0,   0, 0, 1);
    add_row(OP_QUERY_COL_ANY,  0,  0,   0, 1, 0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < n_head; i++)
      send_word(dir_rows[i].op, dir_rows[i].chip, dir_rows[i].col, dir_rows[i].row,
                dir_rows[i].ans);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 58; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 58; end
        default: begin send_idle_pct = 21; stall_pct = 21; end
      endcase
      count = 0;
      while (count < PHASE_WORDS) begin
        send_random(sent);
        count += sent;
      end
    end

    for (int i = n_head; i < dir_rows.size(); i++)
      send_word(dir_rows[i].op, dir_rows[i].chip, dir_rows[i].col, dir_rows[i].row,
                dir_rows[i].ans);
    s_tvalid <= 1'b0;

    // The last accepted word is queued by the monitor at the same edge, so move past it first.
    do @(posedge clk); while (answer_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0) $display("pixel_mask_map_region_query regression: pass");
    else $display("pixel_mask_map_region_query regression: fail");
    $finish;
  end

endmodule
